FILE: design/gre_pkg.sv
package gre_pkg;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int CITY_W = 5;
  localparam int IDX_EXT_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_WR,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic add_rd;
    logic add_wr;
    logic search_start;
    logic expand;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic in_range;
    logic unknown;
    logic search_done;
  } sts_t;

endpackage

FILE: design/gre_ctrl.sv
module gre_ctrl import gre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  output logic out_load,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_add) begin
          if (sts.in_range) begin
            cmd.add_rd = 1'b1;
            state_next = ST_ADD_WR;
          end else begin
            state_next = ST_DONE;
          end
        end else if (sts.unknown) begin
          state_next = ST_DONE;
        end else begin
          cmd.search_start = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.expand = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/gre_dpath.sv
module gre_dpath import gre_pkg::*; #(
  parameter int MAX_CITIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              req_type,
  input  logic [CITY_W-1:0] origin_city,
  input  logic [CITY_W-1:0] dest_city,
  output sts_t              sts,
  output logic              route_found,
  output logic              city_unknown
);

  localparam int CW = $clog2(MAX_CITIES);

  logic                  req_add;
  logic [CITY_W-1:0]     org_q;
  logic [CITY_W-1:0]     dst_q;
  logic [IDX_EXT_W-1:0]  org_ext;
  logic [IDX_EXT_W-1:0]  dst_ext;
  logic [CW-1:0]         org_idx;
  logic [CW-1:0]         dst_idx;
  logic                  in_range;
  logic                  unknown;

  logic [MAX_CITIES-1:0] mem [MAX_CITIES];
  logic [MAX_CITIES-1:0] row_valid;
  logic [MAX_CITIES-1:0] rd_data;
  logic                  rd_vld;
  logic [MAX_CITIES-1:0] row_eff;
  logic [MAX_CITIES-1:0] wr_row;
  logic                  rd_en;
  logic [CW-1:0]         rd_addr;

  logic [MAX_CITIES-1:0] known;
  logic [MAX_CITIES-1:0] reached;
  logic [MAX_CITIES-1:0] expanded;
  logic [MAX_CITIES-1:0] pending;
  logic                  inflight;
  logic [CW-1:0]         pick;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_add <= (req_type == REQ_ADD);
      org_q <= origin_city;
      dst_q <= dest_city;
    end
  end

  assign org_ext = {{(IDX_EXT_W-CITY_W){1'b0}}, org_q};
  assign dst_ext = {{(IDX_EXT_W-CITY_W){1'b0}}, dst_q};
  assign org_idx = org_ext[CW-1:0];
  assign dst_idx = dst_ext[CW-1:0];
  assign in_range = (org_ext < IDX_EXT_W'(MAX_CITIES)) && (dst_ext < IDX_EXT_W'(MAX_CITIES));
  assign unknown = !in_range || !known[org_idx] || !known[dst_idx];

  assign pending = reached & ~expanded;

  always_comb begin
    pick = '0;
    for (int i = MAX_CITIES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = CW'(i);
      end
    end
  end

  // one row read per cycle
  always_comb begin
    rd_en = 1'b0;
    rd_addr = org_idx;
    if (cmd.add_rd || cmd.search_start) begin
      rd_en = 1'b1;
    end else if (cmd.expand && (pending != '0)) begin
      rd_en = 1'b1;
      rd_addr = pick;
    end
  end

  assign row_eff = rd_vld ? rd_data : '0;
  assign wr_row = row_eff | (MAX_CITIES'(1) << dst_idx);

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mem[org_idx] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      known <= '0;
      rd_vld <= 1'b0;
      reached <= '0;
      expanded <= '0;
      inflight <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
      if (cmd.add_wr) begin
        row_valid[org_idx] <= 1'b1;
        known <= known | (MAX_CITIES'(1) << org_idx) | (MAX_CITIES'(1) << dst_idx);
      end
      if (cmd.search_start) begin
        reached <= '0;
        expanded <= '0;
        inflight <= 1'b1;
      end else if (cmd.expand) begin
        if (inflight) begin
          reached <= reached | row_eff;
        end
        if (pending != '0) begin
          expanded[pick] <= 1'b1;
          inflight <= 1'b1;
        end else begin
          inflight <= 1'b0;
        end
      end
    end
  end

  assign sts.is_add = req_add;
  assign sts.in_range = in_range;
  assign sts.unknown = unknown;
  assign sts.search_done = (pending == '0) && !inflight;

  assign route_found = !req_add && !unknown && reached[dst_idx];
  assign city_unknown = !req_add && unknown;

endmodule

FILE: design/graph_reachability_engine_top.sv
// Directed graph of up to MAX_CITIES cities with a reachability query. An add word
// (tuser 0) sets the edge origin->dest and marks both cities known; a query word
// (tuser 1) answers whether dest can be reached from origin over one or more edges,
// or flags an unknown city. The adjacency matrix sits in a single-port memory read
// one row per cycle, so one word is handled at a time. An accepted add passes DECODE,
// ADD_WR and DONE; an out-of-range add or a query that names an unknown city goes
// from DECODE straight to DONE; any other query runs SEARCH, where each city reached
// from origin costs one row read and the search waits whenever it needs a row to
// find the next city. m_tvalid rises when DONE loads the output register. A result
// still held in the output register delays the next one until it is taken. Results
// sit in an output register, so a new word is taken while the last result waits.
// No clearing pass is needed after reset.
module graph_reachability_engine_top import gre_pkg::*; #(
  parameter int MAX_CITIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // origin_city, dest_city
  input  logic [0:0]  s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // route_found, city_unknown
);

  cmd_t cmd;
  sts_t sts;
  logic out_free;
  logic out_load;
  logic res_route;
  logic res_unknown;
  logic out_route;
  logic out_unknown;

  gre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .out_load (out_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  gre_dpath #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (s_tuser[0]),
    .origin_city  (s_tdata[4:0]),
    .dest_city    (s_tdata[9:5]),
    .sts          (sts),
    .route_found  (res_route),
    .city_unknown (res_unknown)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_route <= res_route;
      out_unknown <= res_unknown;
    end
  end

  assign m_tdata = {6'b000000, out_unknown, out_route};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while one is in work");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("route found for an unknown city");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared one cycle after accept");

endmodule
